[sv/spmf_pkg.sv]
// ---------------------------------------------------------------------------
// spmf_pkg
// Types and constants shared by the strict priority multi-level queue.
// ---------------------------------------------------------------------------
package spmf_pkg;

   localparam int LEVELS  = 4;
   localparam int DEPTH   = 16;

   localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SLOTS   = LEVELS * DEPTH;
   localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int DATA_W  = 8;
   localparam int PRIO_W  = 3;
   localparam int STAT_W  = 2;
   localparam int OLVL_W  = 2;

   localparam logic ACT_ENQ = 1'b0;
   localparam logic ACT_DEQ = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPRIO = 2'd3;

   typedef struct packed {
      logic              action;
      logic [DATA_W-1:0] item_data;
      logic [PRIO_W-1:0] priority_level;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_data;
      logic [STAT_W-1:0] status;
      logic [OLVL_W-1:0] out_level;
   } rsp_type;

   // slot store access for one word
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_cmd_type;

   // result fields known at accept time; pop selects the read data
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [OLVL_W-1:0] out_level;
      logic              pop;
   } meta_type;

endpackage

[sv/spmf_store.sv]
// ---------------------------------------------------------------------------
// spmf_store
// Slot storage for all levels: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module spmf_store
   import spmf_pkg::*;
(
   input  logic              clock,
   input  mem_cmd_type       cmd,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [SLOTS];
   logic [DATA_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   // holds its value between reads so a stalled result keeps its data
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

[sv/spmf_ctrl.sv]
// ---------------------------------------------------------------------------
// spmf_ctrl
// Per-level head, tail and count registers, level select and status decode.
// ---------------------------------------------------------------------------
module spmf_ctrl
   import spmf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   output mem_cmd_type cmd,
   output meta_type    meta
);

   logic [PTR_W-1:0] head_ff  [LEVELS];
   logic [PTR_W-1:0] tail_ff  [LEVELS];
   logic [CNT_W-1:0] count_ff [LEVELS];

   logic [LVL_W-1:0] enq_lvl;
   logic [LVL_W-1:0] deq_lvl;
   logic             any_busy;
   logic             bad_prio;
   logic             lvl_full;
   logic             do_push;
   logic             do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lv,
                                                   input logic [PTR_W-1:0] p);
      slot_addr = ADDR_W'(ADDR_W'(lv) * ADDR_W'(DEPTH)) + ADDR_W'(p);
   endfunction

   // lowest-numbered non-empty level wins
   always_comb begin
      deq_lvl  = '0;
      any_busy = 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            deq_lvl  = LVL_W'(i);
            any_busy = 1'b1;
         end
      end
   end

   assign bad_prio = (req.priority_level == '0) || (int'(req.priority_level) > LEVELS);
   assign enq_lvl  = LVL_W'(req.priority_level) - LVL_W'(1);
   assign lvl_full = (count_ff[enq_lvl] >= CNT_W'(DEPTH));
   assign do_push  = (req.action == ACT_ENQ) && !bad_prio && !lvl_full;
   assign do_pop   = (req.action == ACT_DEQ) && any_busy;

   always_comb begin
      cmd.wr_en   = accept && do_push;
      cmd.wr_addr = slot_addr(enq_lvl, tail_ff[enq_lvl]);
      cmd.wr_data = req.item_data;
      cmd.rd_en   = accept && do_pop;
      cmd.rd_addr = slot_addr(deq_lvl, head_ff[deq_lvl]);
   end

   always_comb begin
      meta.pop       = do_pop;
      meta.out_level = '0;
      meta.status    = ST_OK;
      if (req.action == ACT_ENQ) begin
         if (bad_prio) begin
            meta.status = ST_BADPRIO;
         end else begin
            meta.out_level = OLVL_W'(enq_lvl);
            if (lvl_full) begin
               meta.status = ST_FULL;
            end
         end
      end else begin
         if (any_busy) begin
            meta.out_level = OLVL_W'(deq_lvl);
         end else begin
            meta.status = ST_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (accept) begin
         if (do_push) begin
            tail_ff[enq_lvl]  <= ptr_next(tail_ff[enq_lvl]);
            count_ff[enq_lvl] <= count_ff[enq_lvl] + CNT_W'(1);
         end
         if (do_pop) begin
            head_ff[deq_lvl]  <= ptr_next(head_ff[deq_lvl]);
            count_ff[deq_lvl] <= count_ff[deq_lvl] - CNT_W'(1);
         end
      end
   end

endmodule

[sv/strict_priority_multi_fifo_core.sv]
// ---------------------------------------------------------------------------
// strict_priority_multi_fifo_core
// Strict priority multi-level queue: one ring buffer per priority level.
// ---------------------------------------------------------------------------
// Takes one enqueue or dequeue word per cycle unless rsp_ready stalls the
// output, and returns exactly one result word for each: acceptance updates
// the level pointers and counts and reads or writes the slot RAM, then the
// result is registered. Back-to-back words at any mix of levels are served
// without bubbles; the rate is set by the single read and single write port
// of the slot RAM. Dequeue serves the lowest-numbered non-empty level.
// A full level drops the word (status full), a priority of zero or above
// the level count reports bad priority, and a dequeue with all levels empty
// reports empty; out_data is zero on every result but a successful dequeue.
module strict_priority_multi_fifo_core
   import spmf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   mem_cmd_type       cmd;
   meta_type          meta;
   logic [DATA_W-1:0] rd_data;

   logic     s1_valid_ff;
   logic     s1_valid_in;
   meta_type s1_meta_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;

   logic accept;
   logic s1_move;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   spmf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cmd    (cmd),
      .meta   (meta)
   );

   spmf_store u_store (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !out_free);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);
      rsp_in.out_data  = s1_meta_ff.pop ? rd_data : '0;
      rsp_in.status    = s1_meta_ff.status;
      rsp_in.out_level = s1_meta_ff.out_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
